// File: sv/iagg_pkg.sv
`default_nettype none

package iagg_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] delay_type;

   // operation codes of a request beat
   typedef logic [1:0] op_type;
   localparam op_type OP_RAISE = 2'd0;
   localparam op_type OP_TAKE  = 2'd1;
   localparam op_type OP_SCHED = 2'd2;
   localparam op_type OP_TICK  = 2'd3;

   // event sources; the status bit of a source is 1 << code
   typedef logic [1:0] src_type;
   localparam src_type SRC_MCU   = 2'd0;
   localparam src_type SRC_IR    = 2'd1;
   localparam src_type SRC_ACCEL = 2'd2;
   localparam src_type SRC_ALARM = 2'd3;

   // register indexes of the configuration port
   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_SRC_ENABLE = 3'd0;
   localparam reg_index_type REG_PWR_SOURCE = 3'd1;
   localparam reg_index_type REG_IR_MASK    = 3'd2;
   localparam reg_index_type REG_ACCEL_MASK = 3'd3;
   localparam reg_index_type REG_ALARM_MASK = 3'd4;

   localparam byte_type BYTE_ALL_ONES   = 8'hFF;
   localparam byte_type PWR_SOURCE_INIT = 8'h0E;

   typedef struct packed {
      op_type    operation;
      src_type   source;
      byte_type  detail;
      delay_type off_delay;
   } req_beat_type;

endpackage

`default_nettype wire

// File: sv/iagg_req_if.sv
`default_nettype none

interface iagg_req_if;
   import iagg_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   src_type   source;
   byte_type  detail;
   delay_type off_delay;

   modport source_port (output valid, operation, source, detail, off_delay, input ready);
   modport sink_port   (input valid, operation, source, detail, off_delay, output ready);
endinterface

`default_nettype wire

// File: sv/iagg_rsp_if.sv
`default_nettype none

interface iagg_rsp_if;
   import iagg_pkg::*;

   logic     valid;
   logic     ready;
   byte_type source_status;
   byte_type ir_status;
   byte_type accel_status;
   byte_type alarm_status;
   logic     line_asserted;
   logic     host_powered;

   modport source_port (output valid, source_status, ir_status, accel_status, alarm_status,
                        line_asserted, host_powered, input ready);
   modport sink_port   (input valid, source_status, ir_status, accel_status, alarm_status,
                        line_asserted, host_powered, output ready);
endinterface

`default_nettype wire

// File: sv/iagg_csr_if.sv
`default_nettype none

interface iagg_csr_if;
   import iagg_pkg::*;

   logic          valid;
   logic          ready;
   reg_index_type index;
   byte_type      data;

   modport source_port (output valid, index, data, input ready);
   modport sink_port   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/interrupt_aggregator_power_ctrl.sv
// Interrupt aggregator with host power switch.
//
// Channels: req_ch takes one beat per operation (raise, take, schedule off,
// tick); rsp_ch returns exactly one beat for every request beat, in order;
// csr_ch writes the five configuration registers (index 0 to 4, other indexes drop).
// A beat moves on a rising clock edge with valid and ready both high.
//
// Path: a request beat lands in the input register; its result is then
// computed from the latches and loaded into the result register, from
// which the response beat leaves when rsp_ch is ready.
// Throughput: one beat per cycle while rsp_ch is ready, set by the single
// pass of mask, OR and countdown logic between the two registers.
//
// Stall: when rsp_ch is not ready the result register holds; the input
// register, if empty, still takes one more beat, then req_ch.ready drops
// until the result beat leaves.
// Reset (synchronous, active high): latches clear, line released, host off,
// countdown disarmed, masks return to their power-up values.
`default_nettype none

module interrupt_aggregator_power_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   iagg_req_if.sink_port    req_ch,
   iagg_rsp_if.source_port  rsp_ch,
   iagg_csr_if.sink_port    csr_ch
);
   import iagg_pkg::*;

   // configuration registers
   byte_type src_enable_ff;
   byte_type pwr_source_ff;
   byte_type ir_mask_ff;
   byte_type accel_mask_ff;
   byte_type alarm_mask_ff;

   // input register
   logic         req_valid_ff;
   req_beat_type req_beat_ff;

   // aggregator state
   byte_type  src_latch_ff,     src_latch_in;
   byte_type  ir_latch_ff,      ir_latch_in;
   byte_type  accel_latch_ff,   accel_latch_in;
   byte_type  alarm_latch_ff,   alarm_latch_in;
   logic      line_on_ff,       line_on_in;
   logic      power_on_ff,      power_on_in;
   logic      off_pending_ff,   off_pending_in;
   delay_type off_remaining_ff, off_remaining_in;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_src_status_ff,   rsp_src_status_in;
   byte_type rsp_ir_status_ff,    rsp_ir_status_in;
   byte_type rsp_accel_status_ff, rsp_accel_status_in;
   byte_type rsp_alarm_status_ff, rsp_alarm_status_in;

   logic     advance;
   logic     stage_fire;
   byte_type src_bit;
   byte_type masked_detail;
   logic     raise_hit;

   // Advance the pipe whenever the result register is empty or being drained.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign stage_fire   = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration writes; unknown indexes drop.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         src_enable_ff <= BYTE_ALL_ONES;
         pwr_source_ff <= PWR_SOURCE_INIT;
         ir_mask_ff    <= BYTE_ALL_ONES;
         accel_mask_ff <= BYTE_ALL_ONES;
         alarm_mask_ff <= BYTE_ALL_ONES;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SRC_ENABLE: src_enable_ff <= csr_ch.data;
            REG_PWR_SOURCE: pwr_source_ff <= csr_ch.data;
            REG_IR_MASK:    ir_mask_ff    <= csr_ch.data;
            REG_ACCEL_MASK: accel_mask_ff <= csr_ch.data;
            REG_ALARM_MASK: alarm_mask_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         req_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         req_beat_ff <= '{operation: req_ch.operation, source: req_ch.source,
                          detail: req_ch.detail, off_delay: req_ch.off_delay};
      end
   end

   // ---------------------------------------------------------------------
   // Single pass: mask the detail, update latches, power and countdown.
   // ---------------------------------------------------------------------
   assign src_bit = byte_type'(1) << req_beat_ff.source;

   always_comb begin
      unique case (req_beat_ff.source)
         SRC_MCU:   masked_detail = req_beat_ff.detail;
         SRC_IR:    masked_detail = req_beat_ff.detail & ir_mask_ff;
         SRC_ACCEL: masked_detail = req_beat_ff.detail & accel_mask_ff;
         SRC_ALARM: masked_detail = req_beat_ff.detail & alarm_mask_ff;
      endcase
   end

   // the event counts only with surviving detail bits and an enabled source
   assign raise_hit = (masked_detail != '0) && ((src_bit & src_enable_ff) != '0);

   always_comb begin
      src_latch_in        = src_latch_ff;
      ir_latch_in         = ir_latch_ff;
      accel_latch_in      = accel_latch_ff;
      alarm_latch_in      = alarm_latch_ff;
      line_on_in          = line_on_ff;
      power_on_in         = power_on_ff;
      off_pending_in      = off_pending_ff;
      off_remaining_in    = off_remaining_ff;
      rsp_src_status_in   = '0;
      rsp_ir_status_in    = '0;
      rsp_accel_status_in = '0;
      rsp_alarm_status_in = '0;

      unique case (req_beat_ff.operation)
         OP_RAISE: begin
            if (raise_hit) begin
               src_latch_in = src_latch_ff | src_bit;
               line_on_in   = 1'b1;
               if ((src_bit & pwr_source_ff) != '0) begin
                  power_on_in = 1'b1;
               end
               if (req_beat_ff.source == SRC_IR) begin
                  ir_latch_in = ir_latch_ff | masked_detail;
               end
               if (req_beat_ff.source == SRC_ACCEL) begin
                  accel_latch_in = accel_latch_ff | masked_detail;
               end
               if (req_beat_ff.source == SRC_ALARM) begin
                  alarm_latch_in = alarm_latch_ff | masked_detail;
               end
            end
         end
         OP_TAKE: begin
            // report the latches as they stood, then clear and release the line
            rsp_src_status_in   = src_latch_ff;
            rsp_ir_status_in    = ir_latch_ff;
            rsp_accel_status_in = accel_latch_ff;
            rsp_alarm_status_in = alarm_latch_ff;
            src_latch_in        = '0;
            ir_latch_in         = '0;
            accel_latch_in      = '0;
            alarm_latch_in      = '0;
            line_on_in          = 1'b0;
         end
         OP_SCHED: begin
            // overwrite any armed countdown
            off_remaining_in = req_beat_ff.off_delay;
            off_pending_in   = 1'b1;
         end
         OP_TICK: begin
            if (off_pending_ff) begin
               if (off_remaining_ff[15:1] == '0) begin
                  off_remaining_in = '0;
                  off_pending_in   = 1'b0;
                  power_on_in      = 1'b0;
               end else begin
                  off_remaining_in = off_remaining_ff - delay_type'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_latch_ff     <= '0;
         ir_latch_ff      <= '0;
         accel_latch_ff   <= '0;
         alarm_latch_ff   <= '0;
         line_on_ff       <= 1'b0;
         power_on_ff      <= 1'b0;
         off_pending_ff   <= 1'b0;
         off_remaining_ff <= '0;
      end else if (stage_fire) begin
         src_latch_ff     <= src_latch_in;
         ir_latch_ff      <= ir_latch_in;
         accel_latch_ff   <= accel_latch_in;
         alarm_latch_ff   <= alarm_latch_in;
         line_on_ff       <= line_on_in;
         power_on_ff      <= power_on_in;
         off_pending_ff   <= off_pending_in;
         off_remaining_ff <= off_remaining_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_src_status_ff   <= rsp_src_status_in;
         rsp_ir_status_ff    <= rsp_ir_status_in;
         rsp_accel_status_ff <= rsp_accel_status_in;
         rsp_alarm_status_ff <= rsp_alarm_status_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.source_status = rsp_src_status_ff;
   assign rsp_ch.ir_status     = rsp_ir_status_ff;
   assign rsp_ch.accel_status  = rsp_accel_status_ff;
   assign rsp_ch.alarm_status  = rsp_alarm_status_ff;
   // line and power after the item are exactly the state the item left
   assign rsp_ch.line_asserted = line_on_ff;
   assign rsp_ch.host_powered  = power_on_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // the line is up exactly while some source bit is latched
   a_line_tracks_latch: assert property (@(posedge clock) disable iff (reset)
      line_on_ff |-> (src_latch_ff != '0))
      else $error("line asserted with empty source latch");

   a_latch_drives_line: assert property (@(posedge clock) disable iff (reset)
      (src_latch_ff != '0) |-> line_on_ff)
      else $error("source latched but line released");

   // a take leaves the IR, accel and alarm latches clear and the line released
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && (req_beat_ff.operation == OP_TAKE)) |=>
         (!rsp_ch.line_asserted && (ir_latch_ff == '0) && (accel_latch_ff == '0)
          && (alarm_latch_ff == '0)))
      else $error("take did not clear the latches");

   // the countdown only ends by switching the host off
   a_countdown_powers_off: assert property (@(posedge clock) disable iff (reset)
      $fell(off_pending_ff) |-> !power_on_ff)
      else $error("countdown expired with host still powered");

endmodule

`default_nettype wire
